### rtl/rpnc_pkg.sv
package rpnc_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Q16.16 data and divider widths
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int DVD_W  = DATA_W + FRAC_W;
    localparam int STEP_W = $clog2(DVD_W + 1);
    localparam int UPC_W  = 6;

    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_MOD   = 4'd5,
        OP_SWAP  = 4'd6,
        OP_DUP   = 4'd7,
        OP_PEEK  = 4'd8,
        OP_CLEAR = 4'd9,
        OP_POP   = 4'd10
    } t_op;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_ZERODIV = 3'd3,
        STAT_UNKNOWN = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        U_NOP,
        U_POPA,
        U_POPB,
        U_PUSHY,
        U_PUSHA,
        U_PUSHB,
        U_ADD,
        U_SUB,
        U_MUL,
        U_MULFIN,
        U_ZDIV,
        U_ZMOD,
        U_DIVINIT,
        U_MODINIT,
        U_DIVSTEP,
        U_DIVFIN,
        U_MODFIN,
        U_PEEK,
        U_POPRPT,
        U_CLEAR,
        U_UNKNOWN
    } t_uop;

    // Sequencing of the step counter
    typedef enum logic [1:0] {
        NX_NEXT,
        NX_DONE,
        NX_JZ,
        NX_LOOP
    } t_nxt;

    typedef struct packed {
        t_uop             uop;
        t_nxt             nxt;
        logic [UPC_W-1:0] tgt;
    } t_ucw;

    // Program entry points
    localparam logic [UPC_W-1:0] UA_PUSH  = 6'd0;
    localparam logic [UPC_W-1:0] UA_ADD   = 6'd1;
    localparam logic [UPC_W-1:0] UA_SUB   = 6'd6;
    localparam logic [UPC_W-1:0] UA_MUL   = 6'd11;
    localparam logic [UPC_W-1:0] UA_DIV   = 6'd17;
    localparam logic [UPC_W-1:0] UA_MOD   = 6'd24;
    localparam logic [UPC_W-1:0] UA_END   = 6'd31;
    localparam logic [UPC_W-1:0] UA_SWAP  = 6'd32;
    localparam logic [UPC_W-1:0] UA_DUP   = 6'd37;
    localparam logic [UPC_W-1:0] UA_PEEK  = 6'd40;
    localparam logic [UPC_W-1:0] UA_CLEAR = 6'd41;
    localparam logic [UPC_W-1:0] UA_POP   = 6'd42;
    localparam logic [UPC_W-1:0] UA_UNK   = 6'd43;

    function automatic logic [UPC_W-1:0] op_entry(input logic [3:0] op);
        logic [UPC_W-1:0] a;
        unique case (op)
            OP_PUSH:  a = UA_PUSH;
            OP_ADD:   a = UA_ADD;
            OP_SUB:   a = UA_SUB;
            OP_MUL:   a = UA_MUL;
            OP_DIV:   a = UA_DIV;
            OP_MOD:   a = UA_MOD;
            OP_SWAP:  a = UA_SWAP;
            OP_DUP:   a = UA_DUP;
            OP_PEEK:  a = UA_PEEK;
            OP_CLEAR: a = UA_CLEAR;
            OP_POP:   a = UA_POP;
            default:  a = UA_UNK;
        endcase
        return a;
    endfunction

    // Control store. A pop needs one step after any depth change for the
    // registered stack read to settle.
    function automatic t_ucw ucode(input logic [UPC_W-1:0] pc);
        t_ucw w;
        unique case (pc)
            // push
            6'd0:  w = '{U_PUSHY,   NX_DONE, '0};
            // add
            6'd1:  w = '{U_POPB,    NX_NEXT, '0};
            6'd2:  w = '{U_NOP,     NX_NEXT, '0};
            6'd3:  w = '{U_POPA,    NX_NEXT, '0};
            6'd4:  w = '{U_ADD,     NX_NEXT, '0};
            6'd5:  w = '{U_PUSHY,   NX_DONE, '0};
            // sub
            6'd6:  w = '{U_POPB,    NX_NEXT, '0};
            6'd7:  w = '{U_NOP,     NX_NEXT, '0};
            6'd8:  w = '{U_POPA,    NX_NEXT, '0};
            6'd9:  w = '{U_SUB,     NX_NEXT, '0};
            6'd10: w = '{U_PUSHY,   NX_DONE, '0};
            // mul
            6'd11: w = '{U_POPB,    NX_NEXT, '0};
            6'd12: w = '{U_NOP,     NX_NEXT, '0};
            6'd13: w = '{U_POPA,    NX_NEXT, '0};
            6'd14: w = '{U_MUL,     NX_NEXT, '0};
            6'd15: w = '{U_MULFIN,  NX_NEXT, '0};
            6'd16: w = '{U_PUSHY,   NX_DONE, '0};
            // div
            6'd17: w = '{U_POPB,    NX_NEXT, '0};
            6'd18: w = '{U_ZDIV,    NX_JZ,   UA_END};
            6'd19: w = '{U_POPA,    NX_NEXT, '0};
            6'd20: w = '{U_DIVINIT, NX_NEXT, '0};
            6'd21: w = '{U_DIVSTEP, NX_LOOP, '0};
            6'd22: w = '{U_DIVFIN,  NX_NEXT, '0};
            6'd23: w = '{U_PUSHY,   NX_DONE, '0};
            // mod
            6'd24: w = '{U_POPB,    NX_NEXT, '0};
            6'd25: w = '{U_ZMOD,    NX_JZ,   UA_END};
            6'd26: w = '{U_POPA,    NX_NEXT, '0};
            6'd27: w = '{U_MODINIT, NX_NEXT, '0};
            6'd28: w = '{U_DIVSTEP, NX_LOOP, '0};
            6'd29: w = '{U_MODFIN,  NX_NEXT, '0};
            6'd30: w = '{U_PUSHY,   NX_DONE, '0};
            // swap
            6'd32: w = '{U_POPA,    NX_NEXT, '0};
            6'd33: w = '{U_NOP,     NX_NEXT, '0};
            6'd34: w = '{U_POPB,    NX_NEXT, '0};
            6'd35: w = '{U_PUSHA,   NX_NEXT, '0};
            6'd36: w = '{U_PUSHB,   NX_DONE, '0};
            // dup
            6'd37: w = '{U_POPA,    NX_NEXT, '0};
            6'd38: w = '{U_PUSHA,   NX_NEXT, '0};
            6'd39: w = '{U_PUSHA,   NX_DONE, '0};
            // single-step commands
            6'd40: w = '{U_PEEK,    NX_DONE, '0};
            6'd41: w = '{U_CLEAR,   NX_DONE, '0};
            6'd42: w = '{U_POPRPT,  NX_DONE, '0};
            6'd43: w = '{U_UNKNOWN, NX_DONE, '0};
            // zero-divisor exit and unused words
            default: w = '{U_NOP,   NX_DONE, '0};
        endcase
        return w;
    endfunction

    // Keep the smallest nonzero status code
    function automatic t_status raise_status(input t_status cur, input t_status code);
        t_status r;
        r = cur;
        if (cur == STAT_OK || code < cur) begin
            r = code;
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] sat33(input logic [DATA_W:0] s);
        logic [DATA_W-1:0] r;
        r = s[DATA_W-1:0];
        if (s[DATA_W] != s[DATA_W-1]) begin
            r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] sat64(input logic [2*DATA_W-1:0] s);
        logic [DATA_W-1:0] r;
        r = s[DATA_W-1:0];
        if (!((&s[2*DATA_W-1:DATA_W-1]) || !(|s[2*DATA_W-1:DATA_W-1]))) begin
            r = s[2*DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### rtl/rpnc_if.sv
// Command channel
interface rpnc_in_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  op;
    logic signed [31:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

// Result channel
interface rpnc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               has_value;
    logic        [2:0]  status;
    logic        [7:0]  depth;

    modport source (output valid, output result_value, output has_value,
                    output status, output depth, input ready);
    modport sink   (input valid, input result_value, input has_value,
                    input status, input depth, output ready);
endinterface

### rtl/rpn_stack_calculator.sv
// Channel   Dir  Modport  Payload
// i_in      in   sink     op[3:0], value[31:0] (Q16.16)
// o_out     out  source   result_value[31:0], has_value, status[2:0], depth[7:0]
//
// One command at a time, run by a microcoded sequencer. Push, peek, pop,
// clear and unknown take 1 step; add/sub 5; mul 6; swap 5; dup 3; div and
// mod 54 steps (3 on a zero divisor), set by the bit-serial divider (48 steps,
// one quotient bit per cycle). After each command the sequencer returns to idle, where the next is taken.
// Reset empties the stack; stack memory needs no clearing.
// A result waiting in the output register stalls only the last step of the next command.
module rpn_stack_calculator
    import rpnc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rpnc_in_if.sink      i_in,
    rpnc_out_if.source   o_out
);

    // Operand stack memory
    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_mem_q;
    logic              w_en;
    logic [ADDR_W-1:0] w_addr;
    logic [DATA_W-1:0] w_data;
    logic [ADDR_W-1:0] rd_addr;

    // Sequencer and datapath registers
    t_state             r_state,  n_state;
    logic [UPC_W-1:0]   r_pc,     n_pc;
    logic [CNT_W-1:0]   r_depth,  n_depth;
    logic signed [DATA_W-1:0]   r_a, n_a, r_b, n_b;
    logic [DATA_W-1:0]  r_y,      n_y;
    logic signed [2*DATA_W-1:0] r_prod, n_prod;
    logic [DVD_W-1:0]   r_dvd,    n_dvd;
    logic [DATA_W-1:0]  r_dvs,    n_dvs;
    logic [DATA_W-1:0]  r_rem,    n_rem;
    logic [STEP_W-1:0]  r_cnt,    n_cnt;
    logic               r_neg,    n_neg;
    t_status            r_status, n_status;
    logic [DATA_W-1:0]  r_rv,     n_rv;
    logic               r_hv,     n_hv;

    // Output register
    logic               r_out_valid,  n_out_valid;
    logic [DATA_W-1:0]  r_out_rv,     n_out_rv;
    logic               r_out_hv,     n_out_hv;
    t_status            r_out_status, n_out_status;
    logic [7:0]         r_out_depth,  n_out_depth;

    // Step decode and helpers
    t_ucw                       ucw;
    logic                       go;
    logic                       zd_now;
    logic                       nonempty;
    logic [DATA_W-1:0]          abs_a;
    logic [DATA_W-1:0]          abs_b;
    logic [DATA_W:0]            div_sh;
    logic [DATA_W:0]            div_diff;
    logic signed [2*DATA_W-1:0] mul_t;
    logic [DATA_W-1:0]          mod_m;

    assign ucw      = ucode(r_pc);
    assign nonempty = (r_depth != '0);
    assign rd_addr  = ADDR_W'(r_depth - 1'b1);
    assign w_addr   = r_depth[ADDR_W-1:0];
    assign abs_a    = r_a[DATA_W-1] ? DATA_W'(-r_a) : DATA_W'(r_a);
    assign abs_b    = r_b[DATA_W-1] ? DATA_W'(-r_b) : DATA_W'(r_b);
    assign div_sh   = {r_rem, r_dvd[DVD_W-1]};
    assign div_diff = div_sh - {1'b0, r_dvs};
    assign mul_t    = r_prod[2*DATA_W-1] ? ((r_prod + 64'sd65535) >>> FRAC_W)
                                         : (r_prod >>> FRAC_W);
    assign mod_m    = {r_rem[FRAC_W-1:0], {FRAC_W{1'b0}}};

    // Zero divisor: whole value for div, integer part for mod
    always_comb begin
        if (ucw.uop == U_ZDIV) begin
            zd_now = (r_b == '0);
        end else begin
            zd_now = (r_b[DATA_W-1:FRAC_W] == '0) ||
                     ((&r_b[DATA_W-1:FRAC_W]) && (r_b[FRAC_W-1:0] != '0));
        end
    end

    // The final step waits while the output register is still full
    assign go = (r_state == S_RUN) &&
                !(ucw.nxt == NX_DONE && r_out_valid && !o_out.ready);

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_rv;
    assign o_out.has_value    = r_out_hv;
    assign o_out.status       = r_out_status;
    assign o_out.depth        = r_out_depth;

    // Stack memory: one write, one registered read at the top entry
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    // Next state, datapath and sequencing
    always_comb begin
        n_state      = r_state;
        n_pc         = r_pc;
        n_depth      = r_depth;
        n_a          = r_a;
        n_b          = r_b;
        n_y          = r_y;
        n_prod       = r_prod;
        n_dvd        = r_dvd;
        n_dvs        = r_dvs;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_neg        = r_neg;
        n_status     = r_status;
        n_rv         = r_rv;
        n_hv         = r_hv;
        n_out_valid  = r_out_valid;
        n_out_rv     = r_out_rv;
        n_out_hv     = r_out_hv;
        n_out_status = r_out_status;
        n_out_depth  = r_out_depth;
        w_en         = 1'b0;
        w_data       = r_y;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        // Command transaction starts the program
        if (r_state == S_IDLE && i_in.valid) begin
            n_pc     = op_entry(i_in.op);
            n_y      = i_in.value;
            n_status = STAT_OK;
            n_rv     = '0;
            n_hv     = 1'b0;
            n_state  = S_RUN;
        end

        if (go) begin
            // Datapath action of this step
            unique case (ucw.uop)
                U_NOP: begin
                end
                U_POPA, U_POPB: begin
                    if (nonempty) begin
                        n_depth = r_depth - 1'b1;
                        if (ucw.uop == U_POPA) n_a = r_mem_q;
                        else                   n_b = r_mem_q;
                    end else begin
                        if (ucw.uop == U_POPA) n_a = '0;
                        else                   n_b = '0;
                        n_status = raise_status(n_status, STAT_EMPTY);
                    end
                end
                U_PUSHY, U_PUSHA, U_PUSHB: begin
                    if (ucw.uop == U_PUSHA)      w_data = r_a;
                    else if (ucw.uop == U_PUSHB) w_data = r_b;
                    else                         w_data = r_y;
                    if (r_depth < CNT_W'(STACK_DEPTH)) begin
                        w_en    = 1'b1;
                        n_depth = r_depth + 1'b1;
                    end else begin
                        n_status = raise_status(n_status, STAT_FULL);
                    end
                end
                U_ADD: n_y = sat33({r_a[DATA_W-1], r_a} + {r_b[DATA_W-1], r_b});
                U_SUB: n_y = sat33({r_a[DATA_W-1], r_a} - {r_b[DATA_W-1], r_b});
                U_MUL: n_prod = r_a * r_b;
                U_MULFIN: n_y = sat64(mul_t);
                U_ZDIV, U_ZMOD: begin
                    if (zd_now) begin
                        n_status = raise_status(n_status, STAT_ZERODIV);
                    end
                end
                U_DIVINIT: begin
                    n_dvd = {abs_a, {FRAC_W{1'b0}}};
                    n_dvs = abs_b;
                    n_rem = '0;
                    n_cnt = STEP_W'(DVD_W);
                    n_neg = r_a[DATA_W-1] ^ r_b[DATA_W-1];
                end
                U_MODINIT: begin
                    n_dvd = DVD_W'(abs_a[DATA_W-1:FRAC_W]);
                    n_dvs = DATA_W'(abs_b[DATA_W-1:FRAC_W]);
                    n_rem = '0;
                    n_cnt = STEP_W'(DVD_W);
                    n_neg = r_a[DATA_W-1];
                end
                U_DIVSTEP: begin
                    // Restoring division, one quotient bit per step
                    if (!div_diff[DATA_W]) begin
                        n_rem = div_diff[DATA_W-1:0];
                        n_dvd = {r_dvd[DVD_W-2:0], 1'b1};
                    end else begin
                        n_rem = div_sh[DATA_W-1:0];
                        n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
                    end
                    n_cnt = r_cnt - 1'b1;
                end
                U_DIVFIN: begin
                    if (r_neg) begin
                        if (r_dvd > DVD_W'(33'h080000000)) n_y = 32'h80000000;
                        else                               n_y = DATA_W'(-r_dvd[DATA_W-1:0]);
                    end else begin
                        if (r_dvd > DVD_W'(33'h07FFFFFFF)) n_y = 32'h7FFFFFFF;
                        else                               n_y = r_dvd[DATA_W-1:0];
                    end
                end
                U_MODFIN: n_y = r_neg ? DATA_W'(-mod_m) : mod_m;
                U_PEEK, U_POPRPT: begin
                    if (nonempty) begin
                        n_rv = r_mem_q;
                        n_hv = 1'b1;
                        if (ucw.uop == U_POPRPT) n_depth = r_depth - 1'b1;
                    end else begin
                        n_status = raise_status(n_status, STAT_EMPTY);
                    end
                end
                U_CLEAR: n_depth = '0;
                U_UNKNOWN: n_status = raise_status(n_status, STAT_UNKNOWN);
                default: begin
                end
            endcase

            // Step counter
            unique case (ucw.nxt)
                NX_NEXT: n_pc = r_pc + 1'b1;
                NX_JZ:   n_pc = zd_now ? ucw.tgt : UPC_W'(r_pc + 1'b1);
                NX_LOOP: n_pc = (r_cnt == STEP_W'(1)) ? UPC_W'(r_pc + 1'b1) : r_pc;
                NX_DONE: begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_rv     = n_rv;
                    n_out_hv     = n_hv;
                    n_out_status = n_status;
                    n_out_depth  = 8'(n_depth);
                end
                default: n_pc = r_pc;
            endcase
        end
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
        r_a          <= n_a;
        r_b          <= n_b;
        r_y          <= n_y;
        r_prod       <= n_prod;
        r_dvd        <= n_dvd;
        r_dvs        <= n_dvs;
        r_rem        <= n_rem;
        r_cnt        <= n_cnt;
        r_neg        <= n_neg;
        r_status     <= n_status;
        r_rv         <= n_rv;
        r_hv         <= n_hv;
        r_out_rv     <= n_out_rv;
        r_out_hv     <= n_out_hv;
        r_out_status <= n_out_status;
        r_out_depth  <= n_out_depth;
    end

endmodule

### verif/rpnc_checker.sv
// Watches the command and result channels, predicts each result and compares.
module rpnc_checker
    import rpnc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rpnc_in_if   i_cmd,
    rpnc_out_if  i_res,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_seen,
    output int   o_zdiv_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              has_value;
        t_status           status;
        logic [7:0]        depth;
    } t_rpn_result;

    // Shadow copy of the operand stack
    logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int                shadow_depth;

    t_rpn_result       expected_results [$];
    int                err_count;
    int                checked_count;
    int                full_count;
    int                zdiv_count;

    assign o_errors    = err_count;
    assign o_pending   = expected_results.size();
    assign o_checked   = checked_count;
    assign o_full_seen = full_count;
    assign o_zdiv_seen = zdiv_count;

    function automatic longint sx(input logic [DATA_W-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [DATA_W-1:0] clamp_q(input longint x);
        if (x > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (x < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return x[DATA_W-1:0];
    endfunction

    // Lowest nonzero code wins
    function automatic void flag_status(inout t_status st, input t_status code);
        if (st == STAT_OK || code < st) begin
            st = code;
        end
    endfunction

    // Underflow returns zero and flags
    function automatic logic [DATA_W-1:0] pop_operand(inout t_status st);
        if (shadow_depth > 0) begin
            shadow_depth--;
            return shadow_stack[shadow_depth];
        end
        flag_status(st, STAT_EMPTY);
        return '0;
    endfunction

    // Overflow drops the value and flags
    function automatic void push_operand(input logic [DATA_W-1:0] v, inout t_status st);
        if (shadow_depth < STACK_DEPTH) begin
            shadow_stack[shadow_depth] = v;
            shadow_depth++;
        end else begin
            flag_status(st, STAT_FULL);
        end
    endfunction

    // Runs one command on the shadow stack and returns the result it reports
    function automatic t_rpn_result apply_command(input logic [3:0] op,
                                                  input logic [DATA_W-1:0] val);
        t_rpn_result       r;
        t_status           st;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        longint            ia;
        longint            ib;
        longint            rem;
        st = STAT_OK;
        r.value = '0;
        r.has_value = 1'b0;
        case (op)
            OP_PUSH: begin
                push_operand(val, st);
            end
            OP_ADD: begin
                b = pop_operand(st);
                a = pop_operand(st);
                push_operand(clamp_q(sx(a) + sx(b)), st);
            end
            OP_SUB: begin
                b = pop_operand(st);
                a = pop_operand(st);
                push_operand(clamp_q(sx(a) - sx(b)), st);
            end
            OP_MUL: begin
                b = pop_operand(st);
                a = pop_operand(st);
                // integer divide truncates toward zero
                push_operand(clamp_q((sx(a) * sx(b)) / 65536), st);
            end
            OP_DIV: begin
                b = pop_operand(st);
                if (b == '0) begin
                    flag_status(st, STAT_ZERODIV);
                end else begin
                    a = pop_operand(st);
                    push_operand(clamp_q((sx(a) * 65536) / sx(b)), st);
                end
            end
            OP_MOD: begin
                b = pop_operand(st);
                ib = sx(b) / 65536;
                if (ib == 0) begin
                    flag_status(st, STAT_ZERODIV);
                end else begin
                    a = pop_operand(st);
                    ia = sx(a) / 65536;
                    rem = (ia % ib) * 65536;
                    push_operand(rem[DATA_W-1:0], st);
                end
            end
            OP_SWAP: begin
                a = pop_operand(st);
                b = pop_operand(st);
                push_operand(a, st);
                push_operand(b, st);
            end
            OP_DUP: begin
                a = pop_operand(st);
                push_operand(a, st);
                push_operand(a, st);
            end
            OP_PEEK: begin
                if (shadow_depth > 0) begin
                    r.value = shadow_stack[shadow_depth-1];
                    r.has_value = 1'b1;
                end else begin
                    flag_status(st, STAT_EMPTY);
                end
            end
            OP_CLEAR: begin
                shadow_depth = 0;
            end
            OP_POP: begin
                if (shadow_depth > 0) begin
                    r.value = pop_operand(st);
                    r.has_value = 1'b1;
                end else begin
                    flag_status(st, STAT_EMPTY);
                end
            end
            default: begin
                flag_status(st, STAT_UNKNOWN);
            end
        endcase
        r.status = st;
        r.depth = 8'(shadow_depth);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
            err_count++;
        end
    endtask

    // Predict on each command transaction, compare on each result transaction
    always @(posedge i_clk) begin : watch
        t_rpn_result want;
        t_rpn_result fresh;
        if (!i_rst_n) begin
            shadow_depth = 0;
            expected_results.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                fresh = apply_command(i_cmd.op, i_cmd.value);
                if (fresh.status == STAT_FULL) begin
                    full_count++;
                end
                if (fresh.status == STAT_ZERODIV) begin
                    zdiv_count++;
                end
                expected_results.push_back(fresh);
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no command outstanding");
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_value", want.value, i_res.result_value);
                    check_field("has_value", 32'(want.has_value), 32'(i_res.has_value));
                    check_field("status", 32'(want.status), 32'(i_res.status));
                    check_field("depth", 32'(want.depth), 32'(i_res.depth));
                    checked_count++;
                end
            end
        end
    end

    initial begin
        err_count = 0;
        checked_count = 0;
        full_count = 0;
        zdiv_count = 0;
        shadow_depth = 0;
    end

endmodule

### verif/tb_rpn_stack_calculator.sv
// Stimulus and verdict for the RPN calculator; checking lives in rpnc_checker.
module tb_rpn_stack_calculator
    import rpnc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 7;
    localparam int PHASE_ITEMS  = 200;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 1_000_000;

    localparam logic [3:0]  OP_UNK_FIRST = 4'd11;
    localparam logic [3:0]  OP_UNK_LAST  = 4'd15;

    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;
    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_HALF    = 32'h0000_8000;
    localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] Q_NEG_3   = 32'hFFFD_0000;
    localparam logic [31:0] Q_THREE   = 32'h0003_0000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int   send_idle_pct;
    int   recv_idle_pct;
    int   cmd_count;
    int   cycle_count = 0;

    int   errors;
    int   pending;
    int   checked;
    int   full_seen;
    int   zdiv_seen;

    rpnc_in_if  in_if ();
    rpnc_out_if out_if ();

    rpn_stack_calculator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    rpnc_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (in_if),
        .i_res       (out_if),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_full_seen (full_seen),
        .o_zdiv_seen (zdiv_seen)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Result-side backpressure
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout: no finish after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // One command transaction, with random sender gaps ahead of it
    task automatic issue_cmd(input logic [3:0] op, input logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.op    <= op;
        in_if.value <= val;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        cmd_count++;
    endtask

    // Pushes roughly balance the operand-consuming commands
    function automatic logic [3:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 42) return OP_PUSH;
        if (r < 49) return OP_ADD;
        if (r < 56) return OP_SUB;
        if (r < 63) return OP_MUL;
        if (r < 70) return OP_DIV;
        if (r < 76) return OP_MOD;
        if (r < 80) return OP_SWAP;
        if (r < 85) return OP_DUP;
        if (r < 89) return OP_PEEK;
        if (r < 91) return OP_CLEAR;
        if (r < 97) return OP_POP;
        return 4'($urandom_range(OP_UNK_LAST, OP_UNK_FIRST));
    endfunction

    // Mix of raw bits, small integers, fractions and extremes
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(5))
            0: v = $urandom();
            1: v = (int'($urandom_range(40)) - 20) * 65536;
            2: v = {($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            3: begin
                case ($urandom_range(4))
                    0: v = Q_MAX;
                    1: v = Q_MIN;
                    2: v = '0;
                    3: v = Q_ONE;
                    default: v = Q_NEG_ONE;
                endcase
            end
            4: v = {16'($urandom()), 16'h0000};
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Fill past the top, then work on a full stack
    task automatic overflow_burst();
        repeat (STACK_DEPTH + 4) issue_cmd(OP_PUSH, pick_value());
        issue_cmd(OP_DUP, '0);
        issue_cmd(OP_SWAP, '0);
        issue_cmd(OP_PEEK, '0);
        issue_cmd(OP_MUL, '0);
        issue_cmd(OP_PUSH, pick_value());
        issue_cmd(OP_DUP, '0);
        issue_cmd(OP_DIV, '0);
        issue_cmd(OP_POP, '0);
    endtask

    initial begin : stimulus
        int fill_at;
        in_if.valid  <= 1'b0;
        in_if.op     <= OP_PUSH;
        in_if.value  <= '0;
        i_rst_n      <= 1'b0;
        cmd_count     = 0;
        send_idle_pct = 19;
        recv_idle_pct = 84;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty-stack behavior
        issue_cmd(OP_POP, '0);
        issue_cmd(OP_PEEK, '0);
        issue_cmd(OP_ADD, '0);
        issue_cmd(OP_CLEAR, '0);
        issue_cmd(OP_DUP, '0);
        issue_cmd(OP_CLEAR, '0);
        // swap with a single entry leaves it under a zero
        issue_cmd(OP_PUSH, Q_MAX);
        issue_cmd(OP_SWAP, '0);
        issue_cmd(OP_CLEAR, '0);
        // saturating add, sub and mul
        issue_cmd(OP_PUSH, Q_MAX);
        issue_cmd(OP_PUSH, Q_ONE);
        issue_cmd(OP_ADD, '0);
        issue_cmd(OP_PUSH, Q_MIN);
        issue_cmd(OP_SUB, '0);
        issue_cmd(OP_DUP, '0);
        issue_cmd(OP_MUL, '0);
        // zero divisors, including a fraction with no integer part
        issue_cmd(OP_PUSH, '0);
        issue_cmd(OP_DIV, '0);
        issue_cmd(OP_PUSH, Q_HALF);
        issue_cmd(OP_MOD, '0);
        // remainder with negative divisor, then divide and saturating divide
        issue_cmd(OP_PUSH, Q_NEG_3);
        issue_cmd(OP_MOD, '0);
        issue_cmd(OP_PUSH, Q_THREE);
        issue_cmd(OP_DIV, '0);
        issue_cmd(OP_PUSH, Q_MIN);
        issue_cmd(OP_SWAP, '0);
        issue_cmd(OP_DIV, '0);
        issue_cmd(OP_PEEK, '0);
        issue_cmd(OP_POP, '0);
        issue_cmd(OP_UNK_FIRST, Q_MAX);
        issue_cmd(OP_UNK_LAST, Q_MIN);

        // Random traffic under three flow-control mixes
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 84 : 0;
            recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 19 : 0;
            fill_at = $urandom_range(PHASE_ITEMS - 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == fill_at) begin
                    overflow_burst();
                end
                issue_cmd(pick_op(), pick_value());
            end
        end
        in_if.valid <= 1'b0;

        // Drain
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands: corner cases, three stack-fill bursts, random mix",
                 cmd_count);
        $display("%0d results compared, %0d full-stack and %0d zero-divisor results",
                 checked, full_seen, zdiv_seen);
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/rpnc_pkg.sv
rtl/rpnc_if.sv
rtl/rpn_stack_calculator.sv
verif/rpnc_checker.sv
verif/tb_rpn_stack_calculator.sv
